[hdl/bfra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_pkg
// shared types, constants and helpers of the best-fit range allocator
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int MAX_RANGES = 64;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int DIV_CNT_W  = $clog2(ADDR_BITS + 1);

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [ADDR_BITS-1:0] req_size;
        logic [ADDR_BITS-1:0] req_align;
        logic [ADDR_BITS-1:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] alloc_offset;
        logic [ADDR_BITS-1:0] alloc_size;
        logic [ADDR_BITS-1:0] usable_offset;
        logic [ADDR_BITS-1:0] largest_free;
    } result_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] len;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_LSTART,
        OP_LREAD,
        OP_LCHK,
        OP_AREAD,
        OP_DIVSTART,
        OP_ACHK,
        OP_ADEC,
        OP_RMREAD,
        OP_RMWRITE,
        OP_BREAD,
        OP_BCMP,
        OP_FREAD,
        OP_FCMP,
        OP_FDEC,
        OP_IREAD,
        OP_IWRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       size_zero;
        logic       align_zero;
        logic       idx_lt_cnt;
        logic       idx1_lt_cnt;
        logic       idx_gt_pos;
        logic       div_done;
        logic       found;
        logic       need_eq;
        logic       cur_gt;
        logic       start_lt_off;
        logic       mprev;
        logic       mnext;
        logic       full;
    } stat_t;

    function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                     input logic [ADDR_BITS-1:0] b);
        logic [ADDR_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_BITS] ? {ADDR_BITS{1'b1}} : s[ADDR_BITS-1:0];
    endfunction

endpackage

[hdl/bfra_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_div
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bfra_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bfra_pkg::ADDR_BITS-1:0] dividend,
    input  logic [bfra_pkg::ADDR_BITS-1:0] divisor,
    output logic                           done,
    output logic [bfra_pkg::ADDR_BITS-1:0] remainder
);

    logic [bfra_pkg::ADDR_BITS:0]   rem_reg, rem_next;
    logic [bfra_pkg::ADDR_BITS-1:0] dvd_reg, dvd_next;
    logic [bfra_pkg::ADDR_BITS-1:0] dsr_reg, dsr_next;
    logic [bfra_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [bfra_pkg::ADDR_BITS:0]   trial;

    assign trial     = {rem_reg[bfra_pkg::ADDR_BITS-1:0], dvd_reg[bfra_pkg::ADDR_BITS-1]};
    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg[bfra_pkg::ADDR_BITS-1:0];

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
            cnt_next = bfra_pkg::DIV_CNT_W'(bfra_pkg::ADDR_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = trial - {1'b0, dsr_reg};
            else
                rem_next = trial;
            dvd_next = {dvd_reg[bfra_pkg::ADDR_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

endmodule

[hdl/bfra_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_datapath
// range table memory, scan registers, margin and merge arithmetic
// ----------------------------------------------------------------------------
module bfra_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bfra_pkg::cmd_t                 cmd,
    output bfra_pkg::stat_t                stat,
    input  bfra_pkg::req_t                 req_in,
    input  logic                           cfg_we,
    input  logic [bfra_pkg::ADDR_BITS-1:0] cfg_wdata,
    output bfra_pkg::result_t              result
);

    localparam int AW = bfra_pkg::ADDR_BITS;
    localparam int CW = bfra_pkg::CNT_W;
    localparam int IW = bfra_pkg::IDX_W;

    bfra_pkg::entry_t mem [bfra_pkg::MAX_RANGES];
    bfra_pkg::entry_t rd_reg;

    logic [AW-1:0]      block_size_reg, block_size_next;
    bfra_pkg::req_t     req_reg, req_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               found_reg, found_next;
    logic [CW-1:0]      best_idx_reg, best_idx_next;
    logic [AW-1:0]      best_len_reg, best_len_next;
    logic [AW-1:0]      best_start_reg, best_start_next;
    logic [AW-1:0]      best_marg_reg, best_marg_next;
    bfra_pkg::entry_t   cur_reg, cur_next;
    bfra_pkg::entry_t   prev_reg, prev_next;
    logic [1:0]         status_reg, status_next;
    logic [AW-1:0]      aoff_reg, aoff_next;
    logic [AW-1:0]      asize_reg, asize_next;
    logic [AW-1:0]      uoff_reg, uoff_next;
    logic [AW-1:0]      max_reg, max_next;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    bfra_pkg::entry_t   wr_data;

    logic               div_start;
    logic               div_done;
    logic [AW-1:0]      div_rem;

    logic [CW:0]        idx_inc;
    logic [CW-1:0]      idx_dec;
    logic [AW-1:0]      margin;
    logic               fits;
    logic               better;
    logic [AW-1:0]      need;

    bfra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_reg.start),
        .divisor   (req_reg.req_align),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign idx_dec = idx_reg - 1'b1;
    assign margin  = (req_reg.req_align == '0 || div_rem == '0) ? '0
                   : req_reg.req_align - div_rem;
    assign fits    = (margin <= rd_reg.len) && (req_reg.req_size <= rd_reg.len - margin);
    assign better  = !found_reg || (rd_reg.len < best_len_reg);
    assign need    = req_reg.req_size + best_marg_reg;

    assign stat.action       = req_reg.action;
    assign stat.size_zero    = (req_reg.req_size == '0);
    assign stat.align_zero   = (req_reg.req_align == '0);
    assign stat.idx_lt_cnt   = (idx_reg < cnt_reg);
    assign stat.idx1_lt_cnt  = (idx_inc < {1'b0, cnt_reg});
    assign stat.idx_gt_pos   = (idx_reg > pos_reg);
    assign stat.div_done     = div_done;
    assign stat.found        = found_reg;
    assign stat.need_eq      = (need == best_len_reg);
    assign stat.cur_gt       = (cur_reg.start > rd_reg.start);
    assign stat.start_lt_off = (rd_reg.start < req_reg.free_offset);
    assign stat.mprev        = (idx_reg != '0)
                             && ((req_reg.free_offset - prev_reg.start) == prev_reg.len);
    assign stat.mnext        = (idx_reg < cnt_reg)
                             && ((rd_reg.start - req_reg.free_offset) == req_reg.req_size);
    assign stat.full         = (cnt_reg >= CW'(bfra_pkg::MAX_RANGES));

    assign result.status        = status_reg;
    assign result.alloc_offset  = aoff_reg;
    assign result.alloc_size    = asize_reg;
    assign result.usable_offset = uoff_reg;
    assign result.largest_free  = max_reg;

    always_comb
    begin
        block_size_next = cfg_we ? cfg_wdata : block_size_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_marg_next  = best_marg_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        status_next     = status_reg;
        aoff_next       = aoff_reg;
        asize_next      = asize_reg;
        uoff_next       = uoff_reg;
        max_next        = max_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IW-1:0];
        wr_data         = rd_reg;
        div_start       = 1'b0;

        case (cmd.op)
            bfra_pkg::OP_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = '{start: '0, len: block_size_reg};
                cnt_next = (block_size_reg != '0) ? CW'(1) : '0;
            end
            bfra_pkg::OP_ACCEPT:
            begin
                req_next    = req_in;
                idx_next    = '0;
                found_next  = 1'b0;
                status_next = bfra_pkg::ST_OK;
                aoff_next   = '0;
                asize_next  = '0;
                uoff_next   = '0;
            end
            bfra_pkg::OP_LSTART:
            begin
                idx_next = '0;
                max_next = '0;
            end
            bfra_pkg::OP_LREAD, bfra_pkg::OP_AREAD, bfra_pkg::OP_FREAD:
            begin
                rd_en = 1'b1;
            end
            bfra_pkg::OP_LCHK:
            begin
                if (rd_reg.len > max_reg)
                    max_next = rd_reg.len;
                idx_next = idx_inc[CW-1:0];
            end
            bfra_pkg::OP_DIVSTART:
            begin
                div_start = 1'b1;
            end
            bfra_pkg::OP_ACHK:
            begin
                if (fits && better)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = idx_reg;
                    best_len_next   = rd_reg.len;
                    best_start_next = rd_reg.start;
                    best_marg_next  = margin;
                end
                idx_next = idx_inc[CW-1:0];
            end
            bfra_pkg::OP_ADEC:
            begin
                if (!found_reg)
                    status_next = bfra_pkg::ST_NOFIT;
                else
                begin
                    aoff_next  = best_start_reg;
                    asize_next = need;
                    uoff_next  = best_start_reg + best_marg_reg;
                    idx_next   = best_idx_reg;
                    cur_next   = '{start: best_start_reg + need, len: best_len_reg - need};
                end
            end
            bfra_pkg::OP_RMREAD:
            begin
                if (stat.idx1_lt_cnt)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[IW-1:0];
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            bfra_pkg::OP_RMWRITE:
            begin
                wr_en    = 1'b1;
                idx_next = idx_inc[CW-1:0];
            end
            bfra_pkg::OP_BREAD:
            begin
                if (stat.idx1_lt_cnt)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[IW-1:0];
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_reg;
                end
            end
            bfra_pkg::OP_BCMP:
            begin
                wr_en = 1'b1;
                if (stat.cur_gt)
                    idx_next = idx_inc[CW-1:0];
                else
                    wr_data = cur_reg;
            end
            bfra_pkg::OP_FCMP:
            begin
                if (stat.start_lt_off)
                begin
                    prev_next = rd_reg;
                    idx_next  = idx_inc[CW-1:0];
                end
            end
            bfra_pkg::OP_FDEC:
            begin
                pos_next = idx_reg;
                if (stat.mprev)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec[IW-1:0];
                    if (stat.mnext)
                        wr_data = '{start: prev_reg.start,
                                    len: bfra_pkg::sat_add(
                                        bfra_pkg::sat_add(prev_reg.len, req_reg.req_size),
                                        rd_reg.len)};
                    else
                        wr_data = '{start: prev_reg.start,
                                    len: bfra_pkg::sat_add(prev_reg.len, req_reg.req_size)};
                end
                else if (stat.mnext)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{start: req_reg.free_offset,
                                len: bfra_pkg::sat_add(rd_reg.len, req_reg.req_size)};
                end
                else if (stat.full)
                    status_next = bfra_pkg::ST_FULL;
                else
                    idx_next = cnt_reg;
            end
            bfra_pkg::OP_IREAD:
            begin
                if (stat.idx_gt_pos)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[IW-1:0];
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[IW-1:0];
                    wr_data  = '{start: req_reg.free_offset, len: req_reg.req_size};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bfra_pkg::OP_IWRITE:
            begin
                wr_en    = 1'b1;
                idx_next = idx_dec;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= {AW{1'b1}};
            cnt_reg        <= CW'(1);
            idx_reg        <= '0;
            pos_reg        <= '0;
            found_reg      <= 1'b0;
            status_reg     <= bfra_pkg::ST_OK;
        end
        else
        begin
            block_size_reg <= block_size_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        best_idx_reg   <= best_idx_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        best_marg_reg  <= best_marg_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        aoff_reg       <= aoff_next;
        asize_reg      <= asize_next;
        uoff_reg       <= uoff_next;
        max_reg        <= max_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

endmodule

[hdl/bfra_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_ctrl
// sequencer for init, best-fit scan, free-position scan, table shifts and largest-range scan
// ----------------------------------------------------------------------------
module bfra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output bfra_pkg::cmd_t  cmd,
    input  bfra_pkg::stat_t stat
);

    typedef enum logic [21:0] {
        S_RESET    = 22'h000001,
        S_IDLE     = 22'h000002,
        S_DISPATCH = 22'h000004,
        S_INIT     = 22'h000008,
        S_L_START  = 22'h000010,
        S_L_RD     = 22'h000020,
        S_L_CHK    = 22'h000040,
        S_DONE     = 22'h000080,
        S_A_RD     = 22'h000100,
        S_A_DIV    = 22'h000200,
        S_A_WAIT   = 22'h000400,
        S_A_CHK    = 22'h000800,
        S_A_DEC    = 22'h001000,
        S_RM_RD    = 22'h002000,
        S_RM_WR    = 22'h004000,
        S_B_RD     = 22'h008000,
        S_B_CMP    = 22'h010000,
        S_F_RD     = 22'h020000,
        S_F_CMP    = 22'h040000,
        S_F_DEC    = 22'h080000,
        S_I_RD     = 22'h100000,
        S_I_WR     = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bfra_pkg::OP_NONE;
        case (state_reg)
            S_RESET:
            begin
                cmd.op     = bfra_pkg::OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = bfra_pkg::OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.action)
                    bfra_pkg::ACT_INIT:  state_next = S_INIT;
                    bfra_pkg::ACT_ALLOC: state_next = S_A_RD;
                    bfra_pkg::ACT_FREE:  state_next = stat.size_zero ? S_L_START : S_F_RD;
                    default:             state_next = S_L_START;
                endcase
            end
            S_INIT:
            begin
                cmd.op     = bfra_pkg::OP_INIT;
                state_next = S_L_START;
            end
            S_L_START:
            begin
                cmd.op     = bfra_pkg::OP_LSTART;
                state_next = S_L_RD;
            end
            S_L_RD:
            begin
                cmd.op     = bfra_pkg::OP_LREAD;
                state_next = stat.idx_lt_cnt ? S_L_CHK : S_DONE;
            end
            S_L_CHK:
            begin
                cmd.op     = bfra_pkg::OP_LCHK;
                state_next = S_L_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            S_A_RD:
            begin
                cmd.op     = bfra_pkg::OP_AREAD;
                state_next = stat.idx_lt_cnt ? S_A_DIV : S_A_DEC;
            end
            S_A_DIV:
            begin
                if (stat.align_zero)
                    state_next = S_A_CHK;
                else
                begin
                    cmd.op     = bfra_pkg::OP_DIVSTART;
                    state_next = S_A_WAIT;
                end
            end
            S_A_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                cmd.op     = bfra_pkg::OP_ACHK;
                state_next = S_A_RD;
            end
            S_A_DEC:
            begin
                cmd.op = bfra_pkg::OP_ADEC;
                if (!stat.found)
                    state_next = S_L_START;
                else if (stat.need_eq)
                    state_next = S_RM_RD;
                else
                    state_next = S_B_RD;
            end
            S_RM_RD:
            begin
                cmd.op     = bfra_pkg::OP_RMREAD;
                state_next = stat.idx1_lt_cnt ? S_RM_WR : S_L_START;
            end
            S_RM_WR:
            begin
                cmd.op     = bfra_pkg::OP_RMWRITE;
                state_next = S_RM_RD;
            end
            S_B_RD:
            begin
                cmd.op     = bfra_pkg::OP_BREAD;
                state_next = stat.idx1_lt_cnt ? S_B_CMP : S_L_START;
            end
            S_B_CMP:
            begin
                cmd.op     = bfra_pkg::OP_BCMP;
                state_next = stat.cur_gt ? S_B_RD : S_L_START;
            end
            S_F_RD:
            begin
                cmd.op     = bfra_pkg::OP_FREAD;
                state_next = stat.idx_lt_cnt ? S_F_CMP : S_F_DEC;
            end
            S_F_CMP:
            begin
                cmd.op     = bfra_pkg::OP_FCMP;
                state_next = stat.start_lt_off ? S_F_RD : S_F_DEC;
            end
            S_F_DEC:
            begin
                cmd.op = bfra_pkg::OP_FDEC;
                if (stat.mprev && stat.mnext)
                    state_next = S_RM_RD;
                else if (stat.mprev || stat.mnext || stat.full)
                    state_next = S_L_START;
                else
                    state_next = S_I_RD;
            end
            S_I_RD:
            begin
                cmd.op     = bfra_pkg::OP_IREAD;
                state_next = stat.idx_gt_pos ? S_I_WR : S_L_START;
            end
            S_I_WR:
            begin
                cmd.op     = bfra_pkg::OP_IWRITE;
                state_next = S_I_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_RESET;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/best_fit_range_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_range_allocator_core
// best-fit free range allocator with coalescing free, 64-entry sorted table
// ----------------------------------------------------------------------------
// steps: init writes entry 0; alloc scans every range, running the remainder unit
//   per range when an alignment is given, then shifts entries; free scans to the
//   insert point, then merges or shifts entries; every request ends with a largest-range scan
// throughput: one request at a time, next start taken the cycle after done
// results are never stalled: done is high for exactly one cycle
// reset: the reset state loads entry 0 with the block size, busy is high meanwhile
module best_fit_range_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bfra_pkg::req_t                 req,
    output logic                           done,
    output bfra_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [bfra_pkg::ADDR_BITS-1:0] cfg_wdata
);

    bfra_pkg::cmd_t  cmd;
    bfra_pkg::stat_t stat;

    bfra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    bfra_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_in    (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

[hdl/bfra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_checker
// port-level checks of the allocator command interface
// ----------------------------------------------------------------------------
module bfra_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bfra_pkg::result_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("transfer not followed by busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == bfra_pkg::ST_OK || result.status == bfra_pkg::ST_NOFIT
                  || result.status == bfra_pkg::ST_FULL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != bfra_pkg::ST_OK) |-> (result.alloc_size == '0))
        else $error("failed request reports a size");

endmodule

bind best_fit_range_allocator_core bfra_checker u_bfra_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[test/tb_best_fit_range_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_range_allocator_core
// self-checking bench: a directed table then constrained-free random requests
// (alloc-heavy mixes with frees of earlier allocations), every result compared
// against a behavioral best-fit table model kept in the bench
// ----------------------------------------------------------------------------
module tb_best_fit_range_allocator_core;

    localparam logic [1:0] ACT_UNDEF = 2'd3;
    localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

    typedef struct {
        bfra_pkg::req_t    rq;
        logic              chk;
        bfra_pkg::result_t res;
    } vec_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    bfra_pkg::req_t req;
    logic done;
    bfra_pkg::result_t result;
    logic cfg_we;
    logic [bfra_pkg::ADDR_BITS-1:0] cfg_wdata;

    logic [31:0] blk_size;
    logic [31:0] fr_start [bfra_pkg::MAX_RANGES];
    logic [31:0] fr_len [bfra_pkg::MAX_RANGES];
    int fr_cnt;
    bfra_pkg::result_t pending_q[$];
    logic [31:0] held_off[$];
    logic [31:0] held_len[$];
    int errors;
    int n_xfer;
    int n_ok_alloc;
    int n_full;
    int n_nofit;
    vec_t dir_tbl[$];

    best_fit_range_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #200ms;
        $display("best_fit_range_allocator_core test failed");
        $finish;
    end

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL1 : s[31:0];
    endfunction

    function automatic void drop_range(input int p);
        for (int i = p; i + 1 < fr_cnt; i++)
        begin
            fr_start[i] = fr_start[i + 1];
            fr_len[i] = fr_len[i + 1];
        end
        fr_cnt--;
        fr_start[fr_cnt] = '0;
        fr_len[fr_cnt] = '0;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < bfra_pkg::MAX_RANGES; i++)
        begin
            fr_start[i] = '0;
            fr_len[i] = '0;
        end
        fr_len[0] = blk_size;
        fr_cnt = (blk_size != 0) ? 1 : 0;
    endfunction

    function automatic bfra_pkg::result_t allocator_step(input bfra_pkg::req_t r);
        bfra_pkg::result_t o;
        logic found;
        int best;
        int p;
        logic [31:0] mg;
        logic [31:0] bmg;
        logic [31:0] need;
        logic [31:0] ts;
        logic [31:0] tl;
        logic mprev;
        logic mnext;
        o = '0;
        found = 1'b0;
        best = 0;
        bmg = '0;
        if (r.action == bfra_pkg::ACT_INIT)
        begin
            clear_table();
        end
        else if (r.action == bfra_pkg::ACT_ALLOC)
        begin
            for (int i = 0; i < fr_cnt; i++)
            begin
                mg = (r.req_align == 0 || fr_start[i] % r.req_align == 0) ? 32'd0
                     : r.req_align - fr_start[i] % r.req_align;
                if (mg <= fr_len[i] && r.req_size <= fr_len[i] - mg)
                begin
                    if (!found || fr_len[i] < fr_len[best])
                    begin
                        found = 1'b1;
                        best = i;
                        bmg = mg;
                    end
                end
            end
            if (!found)
            begin
                o.status = bfra_pkg::ST_NOFIT;
            end
            else
            begin
                need = r.req_size + bmg;
                o.alloc_offset = fr_start[best];
                o.alloc_size = need;
                o.usable_offset = fr_start[best] + bmg;
                if (need == fr_len[best])
                begin
                    drop_range(best);
                end
                else
                begin
                    fr_start[best] = fr_start[best] + need;
                    fr_len[best] = fr_len[best] - need;
                    for (int i = best; i + 1 < fr_cnt && fr_start[i] > fr_start[i + 1]; i++)
                    begin
                        ts = fr_start[i];
                        tl = fr_len[i];
                        fr_start[i] = fr_start[i + 1];
                        fr_len[i] = fr_len[i + 1];
                        fr_start[i + 1] = ts;
                        fr_len[i + 1] = tl;
                    end
                end
            end
        end
        else if (r.action == bfra_pkg::ACT_FREE && r.req_size != 0)
        begin
            p = 0;
            while (p < fr_cnt && fr_start[p] < r.free_offset)
            begin
                p++;
            end
            mprev = p > 0 && (r.free_offset - fr_start[p - 1]) == fr_len[p - 1];
            mnext = p < fr_cnt && (fr_start[p] - r.free_offset) == r.req_size;
            if (mprev && mnext)
            begin
                fr_len[p - 1] = sat32(sat32(fr_len[p - 1], r.req_size), fr_len[p]);
                drop_range(p);
            end
            else if (mprev)
            begin
                fr_len[p - 1] = sat32(fr_len[p - 1], r.req_size);
            end
            else if (mnext)
            begin
                fr_start[p] = r.free_offset;
                fr_len[p] = sat32(fr_len[p], r.req_size);
            end
            else if (fr_cnt >= bfra_pkg::MAX_RANGES)
            begin
                o.status = bfra_pkg::ST_FULL;
            end
            else
            begin
                for (int i = fr_cnt; i > p; i--)
                begin
                    fr_start[i] = fr_start[i - 1];
                    fr_len[i] = fr_len[i - 1];
                end
                fr_start[p] = r.free_offset;
                fr_len[p] = r.req_size;
                fr_cnt++;
            end
        end
        for (int i = 0; i < fr_cnt; i++)
        begin
            if (fr_len[i] > o.largest_free)
            begin
                o.largest_free = fr_len[i];
            end
        end
        return o;
    endfunction

    function automatic bfra_pkg::req_t mk_req(input logic [1:0] a, input logic [31:0] s,
                                              input logic [31:0] al, input logic [31:0] off);
        bfra_pkg::req_t r;
        r.action = a;
        r.req_size = s;
        r.req_align = al;
        r.free_offset = off;
        return r;
    endfunction

    function automatic bfra_pkg::result_t mk_res(input logic [1:0] st, input logic [31:0] ao,
                                                 input logic [31:0] asz, input logic [31:0] uo,
                                                 input logic [31:0] lf);
        bfra_pkg::result_t o;
        o.status = st;
        o.alloc_offset = ao;
        o.alloc_size = asz;
        o.usable_offset = uo;
        o.largest_free = lf;
        return o;
    endfunction

    function automatic void add_row(input bfra_pkg::req_t r, input logic c,
                                    input bfra_pkg::result_t e);
        vec_t v;
        v.rq = r;
        v.chk = c;
        v.res = e;
        dir_tbl = {dir_tbl, v};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL1;
            2: return $urandom_range(0, 64);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        bfra_pkg::result_t exp_r;
        if (done)
        begin
            n_xfer++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual %h", $time, result);
                errors++;
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (result.status != exp_r.status)
                begin
                    $display("%0t: status exp %0d act %0d", $time, exp_r.status, result.status);
                    errors++;
                end
                if (result.alloc_offset != exp_r.alloc_offset)
                begin
                    $display("%0t: alloc_offset exp %h act %h", $time,
                             exp_r.alloc_offset, result.alloc_offset);
                    errors++;
                end
                if (result.alloc_size != exp_r.alloc_size)
                begin
                    $display("%0t: alloc_size exp %h act %h", $time,
                             exp_r.alloc_size, result.alloc_size);
                    errors++;
                end
                if (result.usable_offset != exp_r.usable_offset)
                begin
                    $display("%0t: usable_offset exp %h act %h", $time,
                             exp_r.usable_offset, result.usable_offset);
                    errors++;
                end
                if (result.largest_free != exp_r.largest_free)
                begin
                    $display("%0t: largest_free exp %h act %h", $time,
                             exp_r.largest_free, result.largest_free);
                    errors++;
                end
                if (exp_r.status == bfra_pkg::ST_FULL)
                begin
                    n_full++;
                end
                if (exp_r.status == bfra_pkg::ST_NOFIT)
                begin
                    n_nofit++;
                end
            end
        end
    end

    // start stays high into the next call unless an idle gap or drain lowers it
    task automatic issue(input bfra_pkg::req_t r, input logic chk,
                         input bfra_pkg::result_t e, input logic gaps);
        bfra_pkg::result_t p;
        if (gaps)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        p = allocator_step(r);
        if (chk && p != e)
        begin
            $display("%0t: table row mismatch exp %h act %h", $time, e, p);
            errors++;
        end
        if (r.action == bfra_pkg::ACT_ALLOC && p.status == bfra_pkg::ST_OK)
        begin
            n_ok_alloc++;
            held_off = {held_off, p.alloc_offset};
            held_len = {held_len, p.alloc_size};
        end
        pending_q = {pending_q, p};
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (300) @(negedge clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        blk_size = v;
    endtask

    task automatic random_phase(input int n_items, input logic gaps);
        bfra_pkg::req_t r;
        int k;
        for (int i = 0; i < n_items; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
            begin
                r = mk_req(bfra_pkg::ACT_INIT, rand_word(), rand_word(), rand_word());
                held_off.delete();
                held_len.delete();
            end
            else if (k < 5)
            begin
                r = mk_req(ACT_UNDEF, rand_word(), rand_word(), rand_word());
            end
            else if (k < 50)
            begin
                r = mk_req(bfra_pkg::ACT_ALLOC, $urandom_range(0, 4096), 0, $urandom);
                if ($urandom_range(0, 2) == 0)
                begin
                    r.req_align = 32'd1 << $urandom_range(0, 12);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    r.req_align = $urandom_range(1, 1000);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    r.req_size = rand_word();
                    r.req_align = rand_word();
                end
            end
            else if (k < 85 && held_off.size() != 0)
            begin
                k = $urandom_range(0, held_off.size() - 1);
                r = mk_req(bfra_pkg::ACT_FREE, held_len[k], $urandom, held_off[k]);
                held_off.delete(k);
                held_len.delete(k);
            end
            else
            begin
                r = mk_req(bfra_pkg::ACT_FREE, rand_word(), rand_word(), rand_word());
            end
            issue(r, 1'b0, '0, gaps);
        end
    endtask

    initial
    begin
        bfra_pkg::result_t z;
        z = '0;
        errors = 0;
        n_xfer = 0;
        n_ok_alloc = 0;
        n_full = 0;
        n_nofit = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        blk_size = ALL1;
        clear_table();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // after reset, extremes, error codes
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd0, 32'd0, 32'd0), 1'b1,
                mk_res(bfra_pkg::ST_OK, 32'd0, 32'd0, 32'd0, ALL1));
        add_row(mk_req(bfra_pkg::ACT_ALLOC, ALL1, 32'd0, ALL1), 1'b1,
                mk_res(bfra_pkg::ST_OK, 32'd0, ALL1, 32'd0, 32'd0));
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd1, 32'd0, 32'd0), 1'b1,
                mk_res(bfra_pkg::ST_NOFIT, 32'd0, 32'd0, 32'd0, 32'd0));
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd0, ALL1, 32'd5), 1'b1, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd100, 32'd0, 32'd100), 1'b1,
                mk_res(bfra_pkg::ST_OK, 32'd0, 32'd0, 32'd0, 32'd100));
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd50, 32'd0, 32'd50), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd10, 32'd0, 32'd200), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd10, 32'd0, 32'd500), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, 32'd290, 32'd0, 32'd210), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd7, 32'd64, 32'd0), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd3, 32'd7, 32'd0), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd1, ALL1, 32'd0), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd1, 32'h8000_0000, 32'd0), 1'b0, z);
        add_row(mk_req(ACT_UNDEF, ALL1, ALL1, ALL1), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, ALL1, 32'd0, 32'd1), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_FREE, ALL1, 32'd0, ALL1), 1'b0, z);
        add_row(mk_req(bfra_pkg::ACT_INIT, ALL1, ALL1, ALL1), 1'b1,
                mk_res(bfra_pkg::ST_OK, 32'd0, 32'd0, 32'd0, ALL1));
        add_row(mk_req(bfra_pkg::ACT_ALLOC, 32'd16, 32'd0, 32'd0), 1'b1,
                mk_res(bfra_pkg::ST_OK, 32'd0, 32'd16, 32'd0, ALL1 - 32'd16));
        foreach (dir_tbl[i])
        begin
            issue(dir_tbl[i].rq, dir_tbl[i].chk, dir_tbl[i].res, 1'b1);
        end

        // fill the table with isolated one-byte holes until it reports full
        write_size(32'd0);
        issue(mk_req(bfra_pkg::ACT_INIT, 0, 0, 0), 1'b1, z, 1'b1);
        for (int i = 0; i < bfra_pkg::MAX_RANGES; i++)
        begin
            issue(mk_req(bfra_pkg::ACT_FREE, 32'd1, 32'd0, 32'd4 * i), 1'b0, z, 1'b1);
        end
        issue(mk_req(bfra_pkg::ACT_FREE, 32'd1, 32'd0, 32'd1000), 1'b1,
              mk_res(bfra_pkg::ST_FULL, 0, 0, 0, 32'd1), 1'b1);
        issue(mk_req(bfra_pkg::ACT_FREE, 32'd1, 32'd0, 32'd1), 1'b0, z, 1'b1);

        write_size(32'd1);
        issue(mk_req(bfra_pkg::ACT_INIT, 0, 0, 0), 1'b1,
              mk_res(bfra_pkg::ST_OK, 0, 0, 0, 32'd1), 1'b1);
        held_off.delete();
        held_len.delete();
        random_phase(60, 1'b1);

        write_size(32'd65536);
        issue(mk_req(bfra_pkg::ACT_INIT, 0, 0, 0), 1'b0, z, 1'b1);
        held_off.delete();
        held_len.delete();
        random_phase(250, 1'b1);
        random_phase(80, 1'b0);

        write_size(32'd5000);
        issue(mk_req(bfra_pkg::ACT_INIT, 0, 0, 0), 1'b0, z, 1'b1);
        held_off.delete();
        held_len.delete();
        random_phase(100, 1'b1);

        write_size(ALL1);
        issue(mk_req(bfra_pkg::ACT_INIT, 0, 0, 0), 1'b0, z, 1'b1);
        held_off.delete();
        held_len.delete();
        random_phase(80, 1'b1);

        drain();
        $display("%0d results checked, %0d good allocs, %0d no-fit, %0d table-full",
                 n_xfer, n_ok_alloc, n_nofit, n_full);
        if (errors == 0 && pending_q.size() == 0)
        begin
            $display("best_fit_range_allocator_core test passed");
        end
        else
        begin
            $display("best_fit_range_allocator_core test failed");
        end
        $finish;
    end

endmodule
